// ===== src/range_match_hit_counter_table_defines.svh =====
// assertion macros shared by the block
`ifndef RANGE_MATCH_HIT_COUNTER_TABLE_DEFINES_SVH
`define RANGE_MATCH_HIT_COUNTER_TABLE_DEFINES_SVH

// same-cycle implication
`define RMHC_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("rmhc: same-cycle check failed");

// next-cycle implication
`define RMHC_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("rmhc: next-cycle check failed");

`endif

// ===== src/rmhc_pkg.sv =====
package rmhc_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W  = 8;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_CHECK      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REGISTER   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNREGISTER = 2'd2;

    // what every cell does when the token passes
    typedef enum logic [1:0] {
        OP_CHECK,
        OP_DUP,
        OP_INSERT,
        OP_FREE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        cell_op_t            op;
        logic [WORD_W-1:0]   owner;
        logic [WORD_W-1:0]   code;
        logic [WORD_W-1:0]   first;
        logic [WORD_W-1:0]   last;
        logic [IDX_W-1:0]    slot_index;
    } rmhc_cmd_t;

    typedef struct packed {
        logic                valid;
        logic                found;
        logic [WORD_W-1:0]   count;
    } rmhc_token_t;

endpackage

// ===== src/rmhc_ifs.sv =====
interface rmhc_in_if import rmhc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [WORD_W-1:0]   owner_id;
    logic [WORD_W-1:0]   code;
    logic [WORD_W-1:0]   range_first;
    logic [WORD_W-1:0]   range_last;
    logic [IDX_W-1:0]    slot_index;

    modport source (
        output valid, mode, owner_id, code, range_first, range_last, slot_index,
        input  ready
    );
    modport sink (
        input  valid, mode, owner_id, code, range_first, range_last, slot_index,
        output ready
    );
endinterface

interface rmhc_out_if import rmhc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op_ok;
    logic [WORD_W-1:0]   hit_count;

    modport source (
        output valid, op_ok, hit_count,
        input  ready
    );
    modport sink (
        input  valid, op_ok, hit_count,
        output ready
    );
endinterface

// ===== src/range_match_hit_counter_table.sv =====
// Table of SLOTS watch entries (owner id, inclusive code range, 32-bit hit
// counter), kept in a row of cells. One request is worked on at a time: a
// token walks the row one cell per clock and the first cell that qualifies
// acts on it. A check or an unregister makes one pass. A register needs a
// duplicate pass and then an insert pass; a register that finds a duplicate
// or a full table stops after the first pass. A mode 3 request, and a check
// or register with an owner id of zero, are answered without a pass. The
// next request is taken while a result still waits on the output.
module range_match_hit_counter_table import rmhc_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rmhc_in_if.sink    req,
    rmhc_out_if.source rsp
);

    rmhc_cmd_t   cmd;
    rmhc_token_t tok [SLOTS+1];

    rmhc_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .launch (tok[0]),
        .tail   (tok[SLOTS])
    );

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        rmhc_cell #(
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

endmodule

// ===== src/rmhc_cell.sv =====
module rmhc_cell import rmhc_pkg::*; #(
    parameter int INDEX = 0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  rmhc_cmd_t   cmd,
    input  rmhc_token_t tok_in,
    output rmhc_token_t tok_out
);

    logic [WORD_W-1:0] owner_reg, owner_next;
    logic [WORD_W-1:0] first_reg, first_next;
    logic [WORD_W-1:0] last_reg, last_next;
    logic [WORD_W-1:0] hits_reg, hits_next;
    rmhc_token_t       tok_reg, tok_next;

    logic              occupied;
    logic              hit;
    logic              take;
    logic [WORD_W-1:0] hits_inc;

    assign occupied = (owner_reg != '0);
    assign hits_inc = hits_reg + WORD_W'(1);

    always_comb
    begin
        unique case (cmd.op)
            OP_CHECK:  hit = occupied && (owner_reg == cmd.owner)
                             && (first_reg <= cmd.code) && (cmd.code <= last_reg);
            OP_DUP:    hit = occupied && (owner_reg == cmd.owner)
                             && (first_reg == cmd.first) && (last_reg == cmd.last);
            OP_INSERT: hit = !occupied;
            OP_FREE:   hit = occupied && (cmd.slot_index == IDX_W'(INDEX));
            default:   hit = 1'b0;
        endcase
    end

    // only the first cell that hits acts on a request
    assign take = tok_in.valid && !tok_in.found && hit;

    always_comb
    begin
        owner_next = owner_reg;
        first_next = first_reg;
        last_next  = last_reg;
        hits_next  = hits_reg;
        tok_next   = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            unique case (cmd.op)
                OP_CHECK:
                begin
                    hits_next      = hits_inc;
                    tok_next.count = hits_inc;
                end
                OP_INSERT:
                begin
                    owner_next = cmd.owner;
                    first_next = cmd.first;
                    last_next  = cmd.last;
                    hits_next  = '0;
                end
                OP_FREE:
                begin
                    owner_next = '0;
                    first_next = '0;
                    last_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            owner_reg <= owner_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
        hits_reg  <= hits_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/rmhc_ctrl.sv =====
`include "range_match_hit_counter_table_defines.svh"

module rmhc_ctrl import rmhc_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rmhc_in_if.sink     req,
    rmhc_out_if.source  rsp,
    output rmhc_cmd_t   cmd,
    output rmhc_token_t launch,
    input  rmhc_token_t tail
);

    localparam int LIVE_W = $clog2(SLOTS + 1);

    ctrl_state_t       state_reg, state_next;
    rmhc_cmd_t         cmd_reg, cmd_next;
    logic              launch_reg, launch_next;
    logic [LIVE_W-1:0] live_reg, live_next;
    logic              res_ok_reg, res_ok_next;
    logic [WORD_W-1:0] res_count_reg, res_count_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [WORD_W-1:0] out_count_reg, out_count_next;

    logic accept;
    logic out_free;
    logic trivial;
    logic scan_end;
    logic second;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // unused mode, or an owner of zero where the owner matters
    assign trivial = (req.mode != MODE_CHECK && req.mode != MODE_REGISTER
                      && req.mode != MODE_UNREGISTER)
                     || (req.mode != MODE_UNREGISTER && req.owner_id == '0);

    assign scan_end = (state_reg == ST_SCAN) && tail.valid;
    // no duplicate and room left: run the insert pass
    assign second   = (cmd_reg.op == OP_DUP) && !tail.found
                      && (live_reg != LIVE_W'(SLOTS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = trivial ? ST_RESULT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_end && !second)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        launch_next    = 1'b0;
        live_next      = live_reg;
        res_ok_next    = res_ok_reg;
        res_count_next = res_count_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_count_next = out_count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next.owner      = req.owner_id;
                    cmd_next.code       = req.code;
                    cmd_next.first      = req.range_first;
                    cmd_next.last       = req.range_last;
                    cmd_next.slot_index = req.slot_index;
                    if (req.mode == MODE_CHECK)
                        cmd_next.op = OP_CHECK;
                    else if (req.mode == MODE_REGISTER)
                        cmd_next.op = OP_DUP;
                    else
                        cmd_next.op = OP_FREE;
                    res_ok_next    = 1'b0;
                    res_count_next = '0;
                    launch_next    = !trivial;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (second)
                    begin
                        cmd_next.op = OP_INSERT;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        res_ok_next    = tail.found && (cmd_reg.op != OP_DUP);
                        res_count_next = (tail.found && cmd_reg.op == OP_CHECK)
                                         ? tail.count : '0;
                        if (tail.found && cmd_reg.op == OP_INSERT)
                            live_next = live_reg + LIVE_W'(1);
                        else if (tail.found && cmd_reg.op == OP_FREE)
                            live_next = live_reg - LIVE_W'(1);
                    end
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_count_next = res_count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        res_ok_reg    <= res_ok_next;
        res_count_reg <= res_count_next;
        out_ok_reg    <= out_ok_next;
        out_count_reg <= out_count_next;
    end

    always_comb
    begin
        launch       = '0;
        launch.valid = launch_reg;
    end

    assign cmd           = cmd_reg;
    assign rsp.valid     = out_valid_reg;
    assign rsp.op_ok     = out_ok_reg;
    assign rsp.hit_count = out_count_reg;

    `RMHC_ASSERT_IMPL(a_launch_in_scan, clk, rst_n, launch_reg, state_reg == ST_SCAN)
    `RMHC_ASSERT_IMPL(a_tail_in_scan, clk, rst_n, tail.valid, state_reg == ST_SCAN)
    `RMHC_ASSERT_IMPL(a_live_bound, clk, rst_n, 1'b1, live_reg <= LIVE_W'(SLOTS))
    `RMHC_ASSERT_NEXT(a_insert_counts, clk, rst_n, scan_end && cmd_reg.op == OP_INSERT && tail.found, live_reg == $past(live_reg) + LIVE_W'(1))

endmodule

// ===== tb/tb.sv =====
module tb;
    import rmhc_pkg::*;

    localparam int SLOTS       = 16;
    localparam int RANDOM_REQS = 1250;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = 2 * SLOTS + 12;
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] owner_id;
        logic [WORD_W-1:0] code;
        logic [WORD_W-1:0] range_first;
        logic [WORD_W-1:0] range_last;
        logic [IDX_W-1:0]  slot_index;
        bit                drain_first;
        int unsigned       gap_after;
    } table_req_t;

    typedef struct packed {
        logic              op_ok;
        logic [WORD_W-1:0] hit_count;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_off;

    rmhc_in_if  req_if ();
    rmhc_out_if rsp_if ();

    range_match_hit_counter_table #(.SLOTS(SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor copy of the watch table
    logic [WORD_W-1:0] watch_owner [SLOTS];
    logic [WORD_W-1:0] watch_lo    [SLOTS];
    logic [WORD_W-1:0] watch_hi    [SLOTS];
    logic [WORD_W-1:0] watch_hits  [SLOTS];

    table_req_t    pending_q [$];
    table_result_t table_results_q [$];
    table_req_t    next_req;
    table_result_t want;

    int unsigned acc_cnt;
    int unsigned res_cnt;
    int unsigned gap_left;
    int unsigned stall_left;
    int          errors = 0;

    int unsigned n_check = 0, n_hit = 0, n_reg = 0, n_stored = 0, n_dup = 0, n_full = 0;
    int unsigned n_unreg = 0, n_freed = 0, n_nop = 0, n_held = 0;

    function automatic table_result_t apply_request(
        input logic [MODE_W-1:0] mode,
        input logic [WORD_W-1:0] owner,
        input logic [WORD_W-1:0] code,
        input logic [WORD_W-1:0] lo,
        input logic [WORD_W-1:0] hi,
        input logic [IDX_W-1:0]  idx
    );
        table_result_t res;
        bit            done;
        int            i;
        res  = '0;
        done = 1'b0;
        case (mode)
            MODE_CHECK:
            begin
                n_check++;
                if (owner != '0)
                begin
                    for (i = 0; i < SLOTS && !done; i++)
                    begin
                        if (watch_owner[i] == owner && watch_lo[i] <= code && code <= watch_hi[i])
                        begin
                            watch_hits[i] = watch_hits[i] + 1'b1;
                            res.op_ok     = 1'b1;
                            res.hit_count = watch_hits[i];
                            done          = 1'b1;
                            n_hit++;
                        end
                    end
                end
            end
            MODE_REGISTER:
            begin
                n_reg++;
                if (owner != '0)
                begin
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (watch_owner[i] == owner && watch_lo[i] == lo && watch_hi[i] == hi)
                            done = 1'b1;
                    end
                    if (done)
                        n_dup++;
                    for (i = 0; i < SLOTS && !done; i++)
                    begin
                        if (watch_owner[i] == '0)
                        begin
                            watch_owner[i] = owner;
                            watch_lo[i]    = lo;
                            watch_hi[i]    = hi;
                            watch_hits[i]  = '0;
                            res.op_ok      = 1'b1;
                            done           = 1'b1;
                            n_stored++;
                        end
                    end
                    if (!done)
                        n_full++;
                end
            end
            MODE_UNREGISTER:
            begin
                n_unreg++;
                if (idx < SLOTS && watch_owner[idx] != '0)
                begin
                    // the counter survives until the slot is reused
                    watch_owner[idx] = '0;
                    watch_lo[idx]    = '0;
                    watch_hi[idx]    = '0;
                    res.op_ok        = 1'b1;
                    n_freed++;
                end
            end
            default:
                n_nop++;
        endcase
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 60);
    endfunction

    task automatic add_req(
        input logic [MODE_W-1:0] mode,
        input logic [WORD_W-1:0] owner,
        input logic [WORD_W-1:0] code,
        input logic [WORD_W-1:0] lo,
        input logic [WORD_W-1:0] hi,
        input logic [IDX_W-1:0]  idx,
        input bit                drain,
        input int unsigned       gap
    );
        table_req_t r;
        r.mode        = mode;
        r.owner_id    = owner;
        r.code        = code;
        r.range_first = lo;
        r.range_last  = hi;
        r.slot_index  = idx;
        r.drain_first = drain;
        r.gap_after   = gap;
        pending_q.push_back(r);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid       <= 1'b0;
            req_if.mode        <= MODE_NOP;
            req_if.owner_id    <= '0;
            req_if.code        <= '0;
            req_if.range_first <= '0;
            req_if.range_last  <= '0;
            req_if.slot_index  <= '0;
            gap_left           <= 0;
            acc_cnt            <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                table_results_q.push_back(apply_request(req_if.mode, req_if.owner_id,
                    req_if.code, req_if.range_first, req_if.range_last, req_if.slot_index));
                acc_cnt <= acc_cnt + 1;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (gap_left != 0)
                begin
                    req_if.valid <= 1'b0;
                    gap_left     <= gap_left - 1;
                end
                else if (pending_q.size() != 0 && !(pending_q[0].drain_first &&
                         acc_cnt + (req_if.valid && req_if.ready) != res_cnt))
                begin
                    next_req = pending_q.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.mode        <= next_req.mode;
                    req_if.owner_id    <= next_req.owner_id;
                    req_if.code        <= next_req.code;
                    req_if.range_first <= next_req.range_first;
                    req_if.range_last  <= next_req.range_last;
                    req_if.slot_index  <= next_req.slot_index;
                    gap_left           <= next_req.gap_after;
                end
                else
                    req_if.valid <= 1'b0;
            end
            else if (hold_off)
                n_held++;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
            res_cnt      <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                res_cnt <= res_cnt + 1;
                if (table_results_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request pending: op_ok=%0b hit_count=%0d",
                             $time, rsp_if.op_ok, rsp_if.hit_count);
                end
                else
                begin
                    want = table_results_q.pop_front();
                    if (rsp_if.op_ok !== want.op_ok)
                    begin
                        errors++;
                        $display("%0t: op_ok expected %0b actual %0b",
                                 $time, want.op_ok, rsp_if.op_ok);
                    end
                    if (rsp_if.hit_count !== want.hit_count)
                    begin
                        errors++;
                        $display("%0t: hit_count expected %0d actual %0d",
                                 $time, want.hit_count, rsp_if.hit_count);
                    end
                end
            end
            if (hold_off)
                rsp_if.ready <= 1'b0;
            else if (stall_left != 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                // stalls come and go in stretches of results
                if (((res_cnt / 200) % 3) != 0 && $urandom_range(0, 5) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    // long receiver hold-off so the block backs up into the request side
    initial
    begin
        hold_off = 1'b0;
        while (acc_cnt < 400)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [WORD_W-1:0] owner_pool [6];
        logic [WORD_W-1:0] lo_pool [8];
        logic [WORD_W-1:0] hi_pool [8];
        logic [MODE_W-1:0] m;
        logic [WORD_W-1:0] own, c, lo, hi;
        logic [IDX_W-1:0]  ix;
        int unsigned       phase_kind, roll, k;
        bit                idle_on, drain;

        rst_n = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            watch_owner[i] = '0;
            watch_lo[i]    = '0;
            watch_hi[i]    = '0;
            watch_hits[i]  = '0;
        end

        // directed: empty table, owner zero, duplicates, empty range, bad index, idle mode
        add_req(MODE_CHECK,      32'd5,        32'd7,        '0,    '0,           '0,   1'b0, 0);
        add_req(MODE_UNREGISTER, '0,           '0,           '0,    '0,           8'd0, 1'b0, 1);
        add_req(MODE_REGISTER,   '0,           '0,           32'd1, 32'd2,        '0,   1'b0, 0);
        add_req(MODE_REGISTER,   32'hFFFFFFFF, '0,           '0,    32'hFFFFFFFF, '0,   1'b0, 0);
        add_req(MODE_CHECK,      32'hFFFFFFFF, 32'd0,        '0,    '0,           '0,   1'b0, 2);
        add_req(MODE_CHECK,      32'hFFFFFFFF, 32'hFFFFFFFF, '0,    '0,           '0,   1'b0, 0);
        add_req(MODE_REGISTER,   32'hFFFFFFFF, '0,           '0,    32'hFFFFFFFF, '0,   1'b0, 0);
        add_req(MODE_REGISTER,   32'd1,        '0,           32'd10, 32'd5,       '0,   1'b0, 0);
        add_req(MODE_CHECK,      32'd1,        32'd7,        '0,    '0,           '0,   1'b0, 0);
        add_req(MODE_CHECK,      32'd1,        32'd10,       '0,    '0,           '0,   1'b0, 0);
        add_req(MODE_CHECK,      '0,           '0,           '0,    '0,           '0,   1'b0, 0);
        add_req(MODE_UNREGISTER, '0,           '0,           '0,    '0,           8'hFF, 1'b0, 0);
        add_req(MODE_UNREGISTER, '0,           '0,           '0,    '0,           IDX_W'(SLOTS),
                1'b0, 0);
        add_req(MODE_NOP,        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                8'hFF, 1'b0, 0);
        add_req(MODE_UNREGISTER, '0,           '0,           '0,    '0,           8'd0, 1'b1, 0);
        add_req(MODE_REGISTER,   32'd2,        '0,           32'd100, 32'd200,    '0,   1'b0, 0);
        add_req(MODE_CHECK,      32'd2,        32'd100,      '0,    '0,           '0,   1'b0, 0);
        add_req(MODE_CHECK,      32'd2,        32'd200,      '0,    '0,           '0,   1'b0, 1);
        add_req(MODE_CHECK,      32'd2,        32'd201,      '0,    '0,           '0,   1'b0, 0);
        add_req(MODE_CHECK,      32'd2,        32'd99,       '0,    '0,           '0,   1'b0, 0);
        add_req(MODE_REGISTER,   32'hFFFFFFFF, '0,           '0,    32'hFFFFFFFF, '0,   1'b0, 0);
        add_req(MODE_UNREGISTER, '0,           '0,           '0,    '0,           8'd1, 1'b0, 0);
        add_req(MODE_UNREGISTER, '0,           '0,           '0,    '0,           8'd1, 1'b0, 0);
        add_req(MODE_CHECK,      32'hFFFFFFFF, 32'h80000000, '0,    '0,           '0,   1'b0, 0);

        // small pools so that registers collide and checks land in live ranges
        owner_pool[0] = 32'd1;
        owner_pool[1] = 32'd2;
        owner_pool[2] = 32'd3;
        owner_pool[3] = 32'h80000000;
        owner_pool[4] = 32'hFFFFFFFF;
        owner_pool[5] = $urandom | 32'd1;
        lo_pool[0] = '0;     hi_pool[0] = 32'hFFFFFFFF;
        lo_pool[1] = 32'd5;  hi_pool[1] = 32'd5;
        lo_pool[2] = 32'd100; hi_pool[2] = 32'd50;
        for (int i = 3; i < 8; i++)
        begin
            lo_pool[i] = $urandom;
            hi_pool[i] = lo_pool[i] + $urandom_range(0, 4000);
        end

        phase_kind = 0;
        idle_on    = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            drain = 1'b0;
            if (n % 50 == 0)
            begin
                phase_kind = $urandom_range(0, 2);
                idle_on    = $urandom_range(0, 3) != 0;
                drain      = $urandom_range(0, 2) == 0;
            end
            m   = MODE_W'($urandom_range(0, 3));
            own = $urandom;
            c   = $urandom;
            lo  = $urandom;
            hi  = $urandom;
            ix  = IDX_W'($urandom_range(0, 255));
            // roughly one request in ten stays pure noise
            if ($urandom_range(0, 9) != 0)
            begin
                roll = $urandom_range(0, 99);
                case (phase_kind)
                    0: m = roll < 60 ? MODE_REGISTER : roll < 90 ? MODE_CHECK :
                           roll < 97 ? MODE_UNREGISTER : MODE_NOP;
                    1: m = roll < 75 ? MODE_CHECK : roll < 87 ? MODE_REGISTER :
                           roll < 97 ? MODE_UNREGISTER : MODE_NOP;
                    default: m = roll < 50 ? MODE_UNREGISTER : roll < 80 ? MODE_CHECK :
                                 roll < 97 ? MODE_REGISTER : MODE_NOP;
                endcase
                own = ($urandom_range(0, 24) == 0) ? '0 : owner_pool[$urandom_range(0, 5)];
                k   = $urandom_range(0, 7);
                if (m == MODE_REGISTER)
                begin
                    lo = lo_pool[k];
                    hi = hi_pool[k];
                end
                case ($urandom_range(0, 4))
                    0: c = lo_pool[k];
                    1: c = hi_pool[k];
                    2: c = lo_pool[k] - 1'b1;
                    3: c = hi_pool[k] + 1'b1;
                    default: c = $urandom_range(hi_pool[k], lo_pool[k]);
                endcase
                if ($urandom_range(0, 6) != 0)
                    ix = IDX_W'($urandom_range(0, SLOTS - 1));
            end
            add_req(m, own, c, lo, hi, ix, drain,
                    (idle_on && $urandom_range(0, 2) != 0) ? pick_gap() : 0);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0 || req_if.valid)
            @(posedge clk);
        while (acc_cnt != res_cnt)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (table_results_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, table_results_q.size());
        end

        $display("ran %0d requests: %0d checks with %0d hits, %0d registers (%0d stored, %0d dup, %0d full)",
                 acc_cnt, n_check, n_hit, n_reg, n_stored, n_dup, n_full);
        $display("%0d unregisters (%0d freed), %0d idle-mode, %0d cycles of request backpressure",
                 n_unreg, n_freed, n_nop, n_held);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rmhc_pkg.sv
src/rmhc_ifs.sv
src/rmhc_cell.sv
src/rmhc_ctrl.sv
src/range_match_hit_counter_table.sv
tb/tb.sv
